@@ hw/rtl/rsdm_pkg.sv @@
// Shared types, constants and helpers of the running statistics drift monitor.
// No dependencies; used by running_stats_drift_monitor and rsdm_checker.
`default_nettype none

package rsdm_pkg;

  localparam int RECENT_WINDOW         = 20;
  localparam int MIN_SAMPLES_FOR_DRIFT = 30;
  localparam int PTR_W                 = $clog2(RECENT_WINDOW);
  localparam int SUM_W                 = 16 + $clog2(RECENT_WINDOW);

  localparam int DIV_W   = 48;               // dividend / quotient width
  localparam int DEN_W   = 33;               // divisor / remainder width
  localparam int SQ_IN_W = 56;               // radicand width
  localparam int SQ_W    = SQ_IN_W / 2;      // root width
  localparam int CNT_W   = $clog2(DIV_W + 1);

  localparam int TDATA_IN_W  = 48;
  localparam int TDATA_OUT_W = 160;

  // Result beat layout, low bit of each field
  localparam int O_RMEAN  = 0;
  localparam int O_RSTD   = 16;
  localparam int O_EMEAN  = 32;
  localparam int O_CMEAN  = 48;
  localparam int O_CONF   = 64;
  localparam int O_STREAK = 80;
  localparam int O_SCORE  = 96;
  localparam int O_DRIFT  = 112;
  localparam int O_EVENTS = 113;
  localparam int O_TOTAL  = 121;

  typedef enum logic [1:0] {
    REG_ETHICS_FLOOR     = 2'd0,
    REG_COHERENCE_TARGET = 2'd1,
    REG_CONF_ALPHA       = 2'd2,
    REG_DRIFT_Z_THRESH   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OBS, ST_CHK, ST_DIV, ST_POST, ST_MUL, ST_M2, ST_SQRT, ST_DRIFT, ST_FIN
  } state_t;

  // What the divider is working on
  typedef enum logic [2:0] {
    OP_REW, OP_ETH, OP_COH, OP_VAR, OP_WIN, OP_Z
  } op_t;

  // Q4.28 to Q4.12, round half up, saturate
  function automatic logic [15:0] q28_to_q12(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [16:0] h;
    begin
      t = {v[31], v} + 33'sd32768;
      h = t[32:16];
      if (h > 17'sd32767)       q28_to_q12 = 16'h7fff;
      else if (h < -17'sd32768) q28_to_q12 = 16'h8000;
      else                      q28_to_q12 = h[15:0];
    end
  endfunction

  // x - acc with one guard bit
  function automatic logic signed [32:0] dev33(input logic signed [31:0] x,
                                               input logic signed [31:0] acc);
    dev33 = {x[31], x} - {acc[31], acc};
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/running_stats_drift_monitor.sv @@
// Running statistics drift monitor: Welford mean/variance of reward, window z-score.
// Depends on rsdm_pkg.
`default_nettype none

// One item at a time. An observe beat runs three divisions for the reward,
// ethics and coherence means, one division of M2 by n-1 and a square root
// (no variance steps while n <= 1). A check beat runs two divisions (window
// mean, then z), only the first when the deviation is zero and none with too
// few samples. All divisions go through one restoring divider, one quotient
// bit a cycle. s_tready is high only while idle; a finished result waits in
// the output register without holding off the next input beat, but the
// following result then waits in the last step until the first is taken.
// Configuration writes belong between items, while nothing is in flight.
module running_stats_drift_monitor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // reward[15:0], ethics[31:16], coherence[47:32]
  input  logic [rsdm_pkg::TDATA_IN_W-1:0]    s_tdata,
  // action: 0 observe, 1 check
  input  logic [0:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // reward avg[15:0], reward std[31:16], ethics avg[47:32], coherence avg[63:48],
  // confidence[79:64], good streak[95:80], z score[111:96], drift now[112],
  // event total[120:113], sample total[152:121], zero[159:153]
  output logic [rsdm_pkg::TDATA_OUT_W-1:0]   m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [15:0]                        cfg_data
);

  localparam int RW   = rsdm_pkg::RECENT_WINDOW;
  localparam int PW   = rsdm_pkg::PTR_W;
  localparam int SW   = rsdm_pkg::SUM_W;
  localparam int DW   = rsdm_pkg::DIV_W;
  localparam int NW   = rsdm_pkg::DEN_W;
  localparam int QW   = rsdm_pkg::SQ_W;
  localparam int QIW  = rsdm_pkg::SQ_IN_W;
  localparam int CW   = rsdm_pkg::CNT_W;

  rsdm_pkg::state_t state, state_next;
  rsdm_pkg::op_t    op;

  logic [12:0] ethics_floor, coherence_target;
  logic [15:0] conf_alpha, drift_z_thresh;

  logic [31:0]        n_seen;
  logic signed [31:0] rwd_avg_acc, eth_avg_acc, coh_avg_acc;
  logic [47:0]        reward_m2_acc;
  logic [15:0]        confidence_reg, good_streak, z_score_reg;
  logic               drift_latched;
  logic [7:0]         drift_event_count;
  logic signed [15:0] recent_rewards [RW];
  logic signed [SW-1:0] recent_sum;
  logic [PW-1:0]      recent_ptr;
  logic [QW-1:0]      std_q16;

  logic signed [15:0] in_reward, in_ethics, in_coherence;
  logic [NW-1:0]      div_rem, div_den;
  logic [DW-1:0]      div_quo;
  logic               div_neg;
  logic [CW-1:0]      step_cnt;
  logic [24:0]        mag1, mag2;
  logic [33:0]        m2_prod;
  logic [QW+1:0]      sq_rem;
  logic [QW-1:0]      sq_root;
  logic [QIW-1:0]     sq_val;

  // ---- combinational helpers ----
  logic [31:0]        count_inc;
  logic signed [31:0] x_r, x_e, x_c;
  logic signed [32:0] d_rew, d_eth, d_coh, d2, q_s;
  logic signed [31:0] racc_new;
  logic               good;
  logic signed [23:0] coh100, tgt99;
  logic [32:0]        conf_prod;
  logic [33:0]        conf_sum;
  logic [15:0]        conf_new;
  logic [NW:0]        div_sh, div_sub;
  logic               div_ge;
  logic [QW+3:0]      sq_sh, sq_trial;
  logic [SW-1:0]      sum_mag;
  logic [NW-1:0]      win_n;
  logic signed [39:0] wmean, diff_s;
  logic [39:0]        diff_mag;
  logic [48:0]        m2_sum;
  logic [28:0]        std_rnd;
  logic [15:0]        std_out;

  assign count_inc = (n_seen == 32'hffff_ffff) ? n_seen : n_seen + 32'd1;
  assign x_r = {in_reward, 16'h0};
  assign x_e = {in_ethics, 16'h0};
  assign x_c = {in_coherence, 16'h0};
  assign d_rew = rsdm_pkg::dev33(x_r, rwd_avg_acc);
  assign d_eth = rsdm_pkg::dev33(x_e, eth_avg_acc);
  assign d_coh = rsdm_pkg::dev33(x_c, coh_avg_acc);
  assign q_s = div_neg ? -$signed(div_quo[32:0]) : $signed(div_quo[32:0]);
  assign racc_new = rwd_avg_acc + q_s[31:0];
  assign d2 = rsdm_pkg::dev33(x_r, racc_new);

  assign coh100 = $signed({{8{in_coherence[15]}}, in_coherence}) * 24'sd100;
  assign tgt99  = $signed({11'd0, coherence_target}) * 24'sd99;
  assign good   = ($signed({in_ethics[15], in_ethics}) >= $signed({4'd0, ethics_floor}))
                  && (coh100 >= tgt99);
  assign conf_prod = 33'(confidence_reg) * 33'(17'h1_0000 - {1'b0, conf_alpha});
  assign conf_sum  = {1'b0, conf_prod} + (good ? {2'd0, conf_alpha, 16'h0} : 34'd0)
                     + 34'd32768;
  assign conf_new  = (conf_sum[33:32] != 2'd0) ? 16'hffff : conf_sum[31:16];

  // restoring divider step
  assign div_sh  = {div_rem, div_quo[DW-1]};
  assign div_ge  = div_sh >= {1'b0, div_den};
  assign div_sub = div_sh - {1'b0, div_den};

  // square root step: two radicand bits a cycle
  assign sq_sh    = {sq_rem, sq_val[QIW-1 -: 2]};
  assign sq_trial = {2'd0, sq_root, 2'b01};

  assign sum_mag = recent_sum[SW-1] ? SW'(-recent_sum) : SW'(recent_sum);
  assign win_n   = (n_seen < 32'(RW)) ? NW'(n_seen) : NW'(RW);
  assign wmean   = div_neg ? -$signed({2'd0, div_quo[37:0]}) : $signed({2'd0, div_quo[37:0]});
  assign diff_s  = wmean - $signed({{8{rwd_avg_acc[31]}}, rwd_avg_acc});
  assign diff_mag = diff_s[39] ? 40'(-diff_s) : 40'(diff_s);

  assign m2_sum  = {1'b0, reward_m2_acc} + {15'd0, m2_prod};
  assign std_rnd = {1'b0, std_q16} + 29'd8;
  assign std_out = (std_rnd[28:20] != 9'd0) ? 16'hffff : std_rnd[19:4];

  assign s_tready  = (state == rsdm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) state <= rsdm_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rsdm_pkg::ST_IDLE:
        if (s_tvalid) state_next = s_tuser[0] ? rsdm_pkg::ST_CHK : rsdm_pkg::ST_OBS;
      rsdm_pkg::ST_OBS: state_next = rsdm_pkg::ST_DIV;
      rsdm_pkg::ST_CHK:
        state_next = (n_seen < 32'(rsdm_pkg::MIN_SAMPLES_FOR_DRIFT))
                     ? rsdm_pkg::ST_FIN : rsdm_pkg::ST_DIV;
      rsdm_pkg::ST_DIV:
        if (step_cnt == CW'(1)) state_next = rsdm_pkg::ST_POST;
      rsdm_pkg::ST_POST:
        unique case (op)
          rsdm_pkg::OP_REW: state_next = rsdm_pkg::ST_MUL;
          rsdm_pkg::OP_ETH: state_next = rsdm_pkg::ST_DIV;
          rsdm_pkg::OP_COH:
            state_next = (n_seen <= 32'd1) ? rsdm_pkg::ST_FIN : rsdm_pkg::ST_DIV;
          rsdm_pkg::OP_VAR: state_next = rsdm_pkg::ST_SQRT;
          rsdm_pkg::OP_WIN:
            state_next = (std_q16 == '0) ? rsdm_pkg::ST_DRIFT : rsdm_pkg::ST_DIV;
          rsdm_pkg::OP_Z:   state_next = rsdm_pkg::ST_DRIFT;
          default:          state_next = rsdm_pkg::ST_FIN;
        endcase
      rsdm_pkg::ST_MUL: state_next = rsdm_pkg::ST_M2;
      rsdm_pkg::ST_M2:  state_next = rsdm_pkg::ST_DIV;
      rsdm_pkg::ST_SQRT:
        if (step_cnt == CW'(1)) state_next = rsdm_pkg::ST_FIN;
      rsdm_pkg::ST_DRIFT: state_next = rsdm_pkg::ST_FIN;
      rsdm_pkg::ST_FIN:
        if (!m_tvalid || m_tready) state_next = rsdm_pkg::ST_IDLE;
      default: state_next = rsdm_pkg::ST_IDLE;
    endcase
  end

  // ---- architectural state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      ethics_floor       <= 13'd3686;
      coherence_target   <= 13'd4018;
      conf_alpha         <= 16'd3277;
      drift_z_thresh     <= 16'd768;
      n_seen             <= '0;
      rwd_avg_acc        <= '0;
      eth_avg_acc        <= '0;
      coh_avg_acc        <= '0;
      reward_m2_acc      <= '0;
      confidence_reg     <= '0;
      good_streak        <= '0;
      drift_latched      <= 1'b0;
      drift_event_count  <= '0;
      z_score_reg        <= '0;
      recent_sum         <= '0;
      recent_ptr         <= '0;
      std_q16            <= '0;
      op                 <= rsdm_pkg::OP_REW;
      m_tvalid           <= 1'b0;
      for (int i = 0; i < RW; i++) recent_rewards[i] <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (rsdm_pkg::cfg_idx_t'(cfg_index))
          rsdm_pkg::REG_ETHICS_FLOOR:     ethics_floor     <= cfg_data[12:0];
          rsdm_pkg::REG_COHERENCE_TARGET: coherence_target <= cfg_data[12:0];
          rsdm_pkg::REG_CONF_ALPHA:       conf_alpha       <= cfg_data;
          rsdm_pkg::REG_DRIFT_Z_THRESH:   drift_z_thresh   <= cfg_data;
          default: ;
        endcase
      end

      if (state == rsdm_pkg::ST_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready)                                         m_tvalid <= 1'b0;

      unique case (state)
        rsdm_pkg::ST_OBS: begin
          recent_sum <= recent_sum + SW'(in_reward) - SW'(recent_rewards[recent_ptr]);
          recent_rewards[recent_ptr] <= in_reward;
          recent_ptr <= (recent_ptr == PW'(RW - 1)) ? '0 : recent_ptr + PW'(1);
          n_seen         <= count_inc;
          confidence_reg <= conf_new;
          if (!good)                     good_streak <= '0;
          else if (good_streak != '1)    good_streak <= good_streak + 16'd1;
          op <= rsdm_pkg::OP_REW;
        end
        rsdm_pkg::ST_CHK: begin
          if (n_seen < 32'(rsdm_pkg::MIN_SAMPLES_FOR_DRIFT)) z_score_reg <= '0;
          op <= rsdm_pkg::OP_WIN;
        end
        rsdm_pkg::ST_POST: begin
          unique case (op)
            rsdm_pkg::OP_REW: rwd_avg_acc <= racc_new;
            rsdm_pkg::OP_ETH: begin
              eth_avg_acc <= eth_avg_acc + q_s[31:0];
              op <= rsdm_pkg::OP_COH;
            end
            rsdm_pkg::OP_COH: begin
              coh_avg_acc <= coh_avg_acc + q_s[31:0];
              if (n_seen <= 32'd1) std_q16 <= '0;
              op <= rsdm_pkg::OP_VAR;
            end
            rsdm_pkg::OP_WIN: begin
              if (std_q16 == '0) z_score_reg <= (diff_mag != '0) ? 16'hffff : 16'h0;
              op <= rsdm_pkg::OP_Z;
            end
            rsdm_pkg::OP_Z:
              z_score_reg <= (div_quo[DW-1:16] != '0) ? 16'hffff : div_quo[15:0];
            default: ;
          endcase
        end
        rsdm_pkg::ST_M2: begin
          reward_m2_acc <= m2_sum[48] ? 48'hffff_ffff_ffff : m2_sum[47:0];
          op <= rsdm_pkg::OP_ETH;
        end
        rsdm_pkg::ST_SQRT:
          if (step_cnt == CW'(1))
            std_q16 <= (sq_sh >= sq_trial) ? {sq_root[QW-2:0], 1'b1} : {sq_root[QW-2:0], 1'b0};
        rsdm_pkg::ST_DRIFT: begin
          if (z_score_reg > drift_z_thresh) begin
            if (!drift_latched) begin
              drift_latched <= 1'b1;
              if (drift_event_count != 8'hff) drift_event_count <= drift_event_count + 8'd1;
            end
          end else begin
            drift_latched <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- datapath: divider, square root, operands, result register ----
  always_ff @(posedge clk) begin
    unique case (state)
      rsdm_pkg::ST_IDLE:
        if (s_tvalid) begin
          in_reward    <= s_tdata[15:0];
          in_ethics    <= s_tdata[31:16];
          in_coherence <= s_tdata[47:32];
        end
      rsdm_pkg::ST_OBS: begin
        div_quo  <= DW'(rsdm_pkg::mag33(d_rew));
        div_neg  <= d_rew[32];
        div_den  <= NW'(count_inc);
        div_rem  <= '0;
        step_cnt <= CW'(DW);
        mag1     <= 25'(rsdm_pkg::mag33(d_rew) >> 8);
      end
      rsdm_pkg::ST_CHK: begin
        div_quo  <= DW'({sum_mag, 16'h0});
        div_neg  <= recent_sum[SW-1];
        div_den  <= win_n;
        div_rem  <= '0;
        step_cnt <= CW'(DW);
      end
      rsdm_pkg::ST_DIV: begin
        div_rem  <= div_ge ? div_sub[NW-1:0] : div_sh[NW-1:0];
        div_quo  <= {div_quo[DW-2:0], div_ge};
        step_cnt <= step_cnt - CW'(1);
      end
      rsdm_pkg::ST_POST: begin
        div_rem  <= '0;
        step_cnt <= (op == rsdm_pkg::OP_VAR) ? CW'(QW) : CW'(DW);
        unique case (op)
          rsdm_pkg::OP_REW: mag2 <= 25'(rsdm_pkg::mag33(d2) >> 8);
          rsdm_pkg::OP_ETH: begin
            div_quo <= DW'(rsdm_pkg::mag33(d_coh));
            div_neg <= d_coh[32];
          end
          rsdm_pkg::OP_COH: begin
            div_quo <= reward_m2_acc;
            div_neg <= 1'b0;
            div_den <= NW'(n_seen - 32'd1);
          end
          rsdm_pkg::OP_VAR: begin
            sq_val   <= {div_quo, 8'h0};
            sq_rem   <= '0;
            sq_root  <= '0;
          end
          rsdm_pkg::OP_WIN: begin
            div_quo <= DW'(diff_mag);
            div_neg <= 1'b0;
            div_den <= NW'({std_q16, 4'h0});
          end
          default: ;
        endcase
      end
      rsdm_pkg::ST_MUL: m2_prod <= 34'((50'(mag1) * 50'(mag2)) >> 16);
      rsdm_pkg::ST_M2: begin
        div_quo  <= DW'(rsdm_pkg::mag33(d_eth));
        div_neg  <= d_eth[32];
        div_rem  <= '0;
        step_cnt <= CW'(DW);
      end
      rsdm_pkg::ST_SQRT: begin
        if (sq_sh >= sq_trial) begin
          sq_rem  <= (QW + 2)'(sq_sh - sq_trial);
          sq_root <= {sq_root[QW-2:0], 1'b1};
        end else begin
          sq_rem  <= sq_sh[QW+1:0];
          sq_root <= {sq_root[QW-2:0], 1'b0};
        end
        sq_val   <= {sq_val[QIW-3:0], 2'b00};
        step_cnt <= step_cnt - CW'(1);
      end
      rsdm_pkg::ST_FIN:
        if (!m_tvalid || m_tready) begin
          m_tdata <= {7'd0, n_seen, drift_event_count, drift_latched, z_score_reg,
                      good_streak, confidence_reg,
                      rsdm_pkg::q28_to_q12(coh_avg_acc),
                      rsdm_pkg::q28_to_q12(eth_avg_acc),
                      std_out,
                      rsdm_pkg::q28_to_q12(rwd_avg_acc)};
        end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/rsdm_checker.sv @@
// Port-level assertions for running_stats_drift_monitor, bound to the top level.
// Depends on rsdm_pkg.
`default_nettype none

module rsdm_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [rsdm_pkg::TDATA_OUT_W-1:0] m_tdata
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // one item at a time: no input beat right after one was taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // std is zero while at most one sample has been seen
  a_std_small_n: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[rsdm_pkg::O_TOTAL +: 32] <= 32'd1)
    |-> m_tdata[rsdm_pkg::O_RSTD +: 16] == 16'd0)
    else $error("nonzero std with n <= 1");

  // a latched drift has always been counted
  a_drift_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[rsdm_pkg::O_DRIFT] |-> m_tdata[rsdm_pkg::O_EVENTS +: 8] != 8'd0)
    else $error("drift latched without an event");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind running_stats_drift_monitor rsdm_checker u_rsdm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for running_stats_drift_monitor: random observe/check beats,
// register changes between phases, predicted results compared per field. Uses rsdm_pkg.
`timescale 1ns / 1ps

typedef struct {
  logic [15:0] rmean, rstd, emean, cmean, conf, streak, score;
  logic        drift;
  logic [7:0]  events;
  logic [31:0] total;
} stats_res_t;

class stats_board;
  logic [12:0] floor_r, target_r;
  logic [15:0] alpha_r, thresh_r;
  longint unsigned n;
  longint rmean_a, emean_a, cmean_a, rsum;
  longint unsigned m2, conf_r, streak_r, events_r, score_r;
  bit latched;
  longint ring[rsdm_pkg::RECENT_WINDOW];
  int ptr;
  stats_res_t pending[$];
  int errors;

  function new();
    floor_r = 3686; target_r = 4018; alpha_r = 3277; thresh_r = 768;
    n = 0; rmean_a = 0; emean_a = 0; cmean_a = 0; rsum = 0; m2 = 0;
    conf_r = 0; streak_r = 0; events_r = 0; score_r = 0; latched = 0;
    foreach (ring[i]) ring[i] = 0;
    ptr = 0; errors = 0;
  endfunction

  function void set_reg(rsdm_pkg::cfg_idx_t idx, logic [15:0] v);
    case (idx)
      rsdm_pkg::REG_ETHICS_FLOOR:     floor_r = v[12:0];
      rsdm_pkg::REG_COHERENCE_TARGET: target_r = v[12:0];
      rsdm_pkg::REG_CONF_ALPHA:       alpha_r = v;
      default:                        thresh_r = v;
    endcase
  endfunction

  function longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
      else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function longint unsigned dev_q16();
    if (n <= 1) return 0;
    return root((m2 / (n - 1)) << 8);
  endfunction

  function logic [15:0] to_q12(longint v);
    longint h;
    h = (v + 32768) >>> 16;
    if (h > 32767) h = 32767;
    if (h < -32768) h = -32768;
    return h[15:0];
  endfunction

  function longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  // note an accepted input beat and queue what it should produce
  function void note_input(bit chk, logic [15:0] r16, e16, c16);
    longint r, e, c, x, d1, d2, wm, diff;
    longint unsigned prod, cf, s, z, sd;
    bit good;
    stats_res_t res;
    r = longint'($signed(r16)); e = longint'($signed(e16)); c = longint'($signed(c16));
    if (!chk) begin
      rsum += r - ring[ptr];
      ring[ptr] = r;
      ptr = (ptr + 1 >= rsdm_pkg::RECENT_WINDOW) ? 0 : ptr + 1;
      if (n < 64'hFFFF_FFFF) n++;
      x = r * 65536;
      d1 = x - rmean_a;
      rmean_a += d1 / longint'(n);
      d2 = x - rmean_a;
      prod = ((absv(d1) >> 8) * (absv(d2) >> 8)) >> 16;
      m2 = (m2 + prod > (64'd1 << 48) - 1) ? (64'd1 << 48) - 1 : m2 + prod;
      emean_a += (e * 65536 - emean_a) / longint'(n);
      cmean_a += (c * 65536 - cmean_a) / longint'(n);
      good = (e >= longint'(floor_r)) && (c * 100 >= longint'(target_r) * 99);
      cf = (conf_r * (65536 - alpha_r) + (good ? (longint'(alpha_r) << 16) : 0) + 32768) >> 16;
      conf_r = cf > 65535 ? 65535 : cf;
      if (!good) streak_r = 0;
      else if (streak_r < 65535) streak_r++;
    end else if (n < rsdm_pkg::MIN_SAMPLES_FOR_DRIFT) begin
      score_r = 0;
    end else begin
      wm = (rsum * 65536) /
           longint'(n < rsdm_pkg::RECENT_WINDOW ? n : rsdm_pkg::RECENT_WINDOW);
      diff = absv(wm - rmean_a);
      s = dev_q16();
      if (s == 0) z = diff != 0 ? 65535 : 0;
      else begin
        z = diff / (s * 16);
        if (z > 65535) z = 65535;
      end
      score_r = z;
      if (z > thresh_r) begin
        if (!latched) begin
          latched = 1;
          if (events_r < 255) events_r++;
        end
      end else latched = 0;
    end
    sd = (dev_q16() + 8) >> 4;
    res.rmean = to_q12(rmean_a);
    res.rstd = sd > 65535 ? 16'hFFFF : sd[15:0];
    res.emean = to_q12(emean_a);
    res.cmean = to_q12(cmean_a);
    res.conf = conf_r[15:0];
    res.streak = streak_r[15:0];
    res.score = score_r[15:0];
    res.drift = latched;
    res.events = events_r[7:0];
    res.total = n[31:0];
    pending.push_back(res);
  endfunction

  task report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task check_result(logic [rsdm_pkg::TDATA_OUT_W-1:0] d);
    stats_res_t w, g;
    if (pending.size() == 0) begin
      report("unexpected result beat", 1, 0);
      return;
    end
    w = pending.pop_front();
    g.rmean  = d[rsdm_pkg::O_RMEAN +: 16];
    g.rstd   = d[rsdm_pkg::O_RSTD +: 16];
    g.emean  = d[rsdm_pkg::O_EMEAN +: 16];
    g.cmean  = d[rsdm_pkg::O_CMEAN +: 16];
    g.conf   = d[rsdm_pkg::O_CONF +: 16];
    g.streak = d[rsdm_pkg::O_STREAK +: 16];
    g.score  = d[rsdm_pkg::O_SCORE +: 16];
    g.drift  = d[rsdm_pkg::O_DRIFT];
    g.events = d[rsdm_pkg::O_EVENTS +: 8];
    g.total  = d[rsdm_pkg::O_TOTAL +: 32];
    if (g.rmean !== w.rmean) report("reward_avg", g.rmean, w.rmean);
    if (g.rstd !== w.rstd) report("reward_std", g.rstd, w.rstd);
    if (g.emean !== w.emean) report("ethics_avg", g.emean, w.emean);
    if (g.cmean !== w.cmean) report("coherence_avg", g.cmean, w.cmean);
    if (g.conf !== w.conf) report("confidence", g.conf, w.conf);
    if (g.streak !== w.streak) report("good_streak", g.streak, w.streak);
    if (g.score !== w.score) report("z_score", g.score, w.score);
    if (g.drift !== w.drift) report("drift_now", g.drift, w.drift);
    if (g.events !== w.events) report("event_total", g.events, w.events);
    if (g.total !== w.total) report("sample_total", g.total, w.total);
    if (d[159:153] !== 7'd0) report("pad", d[159:153], 0);
  endtask
endclass

module tb;
  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [rsdm_pkg::TDATA_IN_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid, m_tready = 0;
  logic [rsdm_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  bit calm = 0;
  stats_board sb = new();

  always #1 clk = ~clk;

  running_stats_drift_monitor dut (.*);

  // receiver: random stall bursts, checks every result beat
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = (!calm && $urandom_range(3) == 0) ? $urandom_range(13, 1) : 0;
      m_tready <= (hold == 0);
      repeat (hold) @(posedge clk);
      m_tready <= 1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
      sb.check_result(m_tdata);
    end
  end

  task automatic send(bit chk, logic [15:0] r, e, c);
    if (!calm && $urandom_range(3) == 0) repeat ($urandom_range(13, 1)) @(posedge clk);
    s_tvalid <= 1;
    s_tuser <= chk;
    s_tdata <= {c, e, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(chk, r, e, c);
    s_tvalid <= 0;
    // the block stays busy for a while after it takes a beat
    @(posedge clk);
  endtask

  task automatic write_reg(rsdm_pkg::cfg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // mostly plausible samples near the good thresholds, some wild values, some check beats
  task automatic random_item(int spread);
    logic [15:0] r, e, c;
    if ($urandom_range(9) == 0) begin
      send(1, 16'($urandom), 16'($urandom), 16'($urandom));
      return;
    end
    if ($urandom_range(7) == 0) begin
      r = 16'($urandom); e = 16'($urandom); c = 16'($urandom);
    end else begin
      r = 16'(2048 + $signed($urandom_range(2 * spread)) - spread);
      e = 16'(3400 + $urandom_range(700));
      c = 16'(3850 + $urandom_range(250));
    end
    send(0, r, e, c);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: checks too early, field extremes, floor/target boundaries
    send(1, 0, 0, 0);
    send(0, 16'h7fff, 16'h7fff, 16'h7fff);
    send(1, 0, 0, 0);
    send(0, 16'h8000, 16'h8000, 16'h8000);
    send(0, 16'hffff, 16'hffff, 16'hffff);
    send(0, 0, 16'd3686, 16'd3978);
    send(0, 0, 16'd3685, 16'd3978);
    send(0, 0, 16'd3686, 16'd3977);
    repeat (8) send(0, 16'd1000, 16'd4000, 16'd4000);
    drain();
    // constant samples: the recent window holds equal values once enough samples
    repeat (40) send(0, 16'd1000, 16'd4000, 16'd4000);
    send(1, 0, 0, 0);
    send(0, 16'h7fff, 16'd4000, 16'd4000);
    send(1, 0, 0, 0);
    send(1, 0, 0, 0);
    drain();
    write_reg(rsdm_pkg::REG_ETHICS_FLOOR, 0);
    write_reg(rsdm_pkg::REG_COHERENCE_TARGET, 16'd4096);
    write_reg(rsdm_pkg::REG_CONF_ALPHA, 16'hffff);
    write_reg(rsdm_pkg::REG_DRIFT_Z_THRESH, 0);
    for (int i = 0; i < 200; i++) random_item(i < 150 ? 300 : 20000);
    drain();
    write_reg(rsdm_pkg::REG_ETHICS_FLOOR, 16'd4096);
    write_reg(rsdm_pkg::REG_COHERENCE_TARGET, 16'd3891);
    write_reg(rsdm_pkg::REG_CONF_ALPHA, 16'd1);
    write_reg(rsdm_pkg::REG_DRIFT_Z_THRESH, 16'hffff);
    for (int i = 0; i < 150; i++) random_item(2000);
    drain();
    write_reg(rsdm_pkg::REG_ETHICS_FLOOR, 16'h1fff);
    write_reg(rsdm_pkg::REG_CONF_ALPHA, 0);
    write_reg(rsdm_pkg::REG_DRIFT_Z_THRESH, 16'd200);
    for (int i = 0; i < 150; i++) random_item(8000);
    drain();
    write_reg(rsdm_pkg::REG_ETHICS_FLOOR, 16'd3686);
    write_reg(rsdm_pkg::REG_COHERENCE_TARGET, 16'd4018);
    write_reg(rsdm_pkg::REG_CONF_ALPHA, 16'd3277);
    write_reg(rsdm_pkg::REG_DRIFT_Z_THRESH, 16'd768);
    for (int i = 0; i < 120; i++) random_item(i % 40 < 20 ? 100 : 12000);
    calm = 1;
    for (int i = 0; i < 80; i++) random_item(4000);
    drain();
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end
endmodule
